// ===== rtl/baro_pressure_compensation_top_defines.svh =====
// Assertion macros used by the barometer compensation datapath.
`ifndef BARO_PRESSURE_COMPENSATION_TOP_DEFINES_SVH
`define BARO_PRESSURE_COMPENSATION_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bpc_pkg.sv =====
// Shared types, register indexes and calibration decode for the barometer compensation.
package bpc_pkg;

	localparam int OUT_FRAC_BITS_DEF = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_MID  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI   = 2'd3;

	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [23:0] raw_temperature;
	} bpc_in_t;

	typedef struct packed {
		logic [22:0]        pressure_pa;
		logic signed [15:0] temperature_c;
	} bpc_out_t;

	// Calibration words, sign- or zero-extended so all products stay signed.
	typedef struct packed {
		logic [15:0]        t1;
		logic signed [16:0] t2;
		logic signed [7:0]  t3;
		logic signed [16:0] p1m;   // p1 - 16384
		logic signed [16:0] p2m;   // p2 - 16384
		logic signed [7:0]  p3;
		logic signed [7:0]  p4;
		logic signed [16:0] p5;
		logic signed [16:0] p6;
		logic signed [7:0]  p7;
		logic signed [7:0]  p8;
		logic signed [15:0] p9;
		logic signed [7:0]  p10;
		logic signed [7:0]  p11;
	} bpc_calib_t;

	function automatic bpc_calib_t decode_calib(input logic [39:0] tc,
			input logic [47:0] lo, input logic [47:0] mid, input logic [31:0] hi);
		bpc_calib_t c;
		c.t1  = tc[15:0];
		c.t2  = $signed({1'b0, tc[31:16]});
		c.t3  = $signed(tc[39:32]);
		c.p1m = 17'($signed(lo[15:0])) - 17'sd16384;
		c.p2m = 17'($signed(lo[31:16])) - 17'sd16384;
		c.p3  = $signed(lo[39:32]);
		c.p4  = $signed(lo[47:40]);
		c.p5  = $signed({1'b0, mid[15:0]});
		c.p6  = $signed({1'b0, mid[31:16]});
		c.p7  = $signed(mid[39:32]);
		c.p8  = $signed(mid[47:40]);
		c.p9  = $signed(hi[15:0]);
		c.p10 = $signed(hi[23:16]);
		c.p11 = $signed(hi[31:24]);
		return c;
	endfunction

endpackage

// ===== rtl/bpc_pipe.sv =====
// Ten-stage compensation datapath: temperature linearization, then the pressure polynomial.
`include "baro_pressure_compensation_top_defines.svh"

module bpc_pipe #(
	parameter int OUT_FRAC_BITS = bpc_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bpc_pkg::bpc_calib_t cal,
	input  logic                in_valid,
	output logic                in_stall,
	input  bpc_pkg::bpc_in_t    in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bpc_pkg::bpc_out_t   out_data
);
	import bpc_pkg::*;

	localparam int NS = 9;
	localparam int RS = 16 - OUT_FRAC_BITS;
	localparam logic signed [49:0] RND_HALF = 50'sd1 <<< (RS - 1);
	localparam logic signed [60:0] TQ_HALF  = 61'sd1 <<< 35;
	localparam logic signed [60:0] TC_HALF  = 61'sd1 <<< 39;

	logic [NS:1]   v_q;
	logic [NS+1:1] en;
	logic          ov_q;

	always_comb begin
		en[NS+1] = !ov_q || !out_stall;
		for (int k = NS; k >= 1; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end
	assign in_stall  = !en[1];
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q  <= '0;
			ov_q <= 1'b0;
		end else begin
			if (en[1]) v_q[1] <= in_valid;
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
			if (en[NS+1]) ov_q <= v_q[NS];
		end
	end

	// stage registers
	logic signed [24:0] d_s1;
	logic [23:0]        p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, p_s7, p_s8;
	logic signed [41:0] dt2_s2;
	logic signed [49:0] dd_s2;
	logic [47:0]        pp_s2;
	logic signed [60:0] num_s3;
	logic [27:0]        q_s3, q_s4, q_s5, q_s6;
	logic signed [24:0] tq_s4, tq_s5;
	logic signed [15:0] tc_s4, tc_s5, tc_s6, tc_s7, tc_s8, tc_s9;
	logic signed [36:0] tsq_s5;
	logic signed [41:0] p6tq_s5, p6tq_s6, p6tq_s7, p2tq_s5, p2tq_s6, p2tq_s7;
	logic signed [32:0] p10tq_s5;
	logic signed [47:0] tcu_s6;
	logic signed [44:0] p7tsq_s6, p7tsq_s7, p3tsq_s6, p3tsq_s7;
	logic signed [31:0] coef_s6;
	logic signed [55:0] p8tcu_s7, p4tcu_s7;
	logic signed [60:0] qc_s7;
	logic [51:0]        qp_s7;
	logic signed [47:0] o1_s8, o1_s9, o2_s9, o3_s9;
	logic signed [39:0] sens_s8;
	logic signed [36:0] o3a_s8;
	logic signed [60:0] qpp_s8;

	// combinational terms per stage
	logic signed [24:0] d_c;
	logic signed [41:0] dt2_c;
	logic signed [49:0] dd_c;
	logic [47:0]        pp_c;
	logic signed [57:0] dt3_c;
	logic signed [60:0] num_c, tqf, tcf;
	logic signed [15:0] tc_c;
	logic signed [49:0] tsqf;
	logic signed [41:0] p6tq_c, p2tq_c;
	logic signed [32:0] p10tq_c;
	logic signed [61:0] tcuf;
	logic signed [44:0] p7tsq_c, p3tsq_c;
	logic signed [31:0] coef_c;
	logic signed [55:0] p8tcu_c, p4tcu_c;
	logic signed [60:0] qc_c, qpp_c;
	logic [51:0]        qp_c;
	logic signed [47:0] o1_c, o3_c;
	logic signed [39:0] sens_c;
	logic signed [64:0] o2f;
	logic signed [49:0] sum_c, prf;
	bpc_out_t           res_c;

	always_comb begin
		d_c   = $signed({1'b0, in_data.raw_temperature}) - $signed({1'b0, cal.t1, 8'h00});
		dt2_c = d_s1 * cal.t2;
		dd_c  = d_s1 * d_s1;
		pp_c  = p_s1 * p_s1;
		dt3_c = dd_s2 * cal.t3;
		num_c = (61'(dt2_s2) <<< 18) + 61'(dt3_c);
		tqf   = (num_s3 + TQ_HALF) >>> 36;
		tcf   = (num_s3 + TC_HALF) >>> 40;
		if (tcf > 61'sd32767)       tc_c = 16'sh7fff;
		else if (tcf < -61'sd32768) tc_c = -16'sh8000;
		else                        tc_c = tcf[15:0];
		tsqf    = tq_s4 * tq_s4;
		p6tq_c  = cal.p6 * tq_s4;
		p2tq_c  = cal.p2m * tq_s4;
		p10tq_c = cal.p10 * tq_s4;
		tcuf    = tsq_s5 * tq_s5;
		p7tsq_c = cal.p7 * tsq_s5;
		p3tsq_c = cal.p3 * tsq_s5;
		coef_c  = (32'(cal.p9) <<< 12) + 32'(p10tq_s5);
		p8tcu_c = cal.p8 * tcu_s6;
		p4tcu_c = cal.p4 * tcu_s6;
		qc_c    = $signed({1'b0, q_s6}) * coef_s6;
		qp_c    = q_s6 * p_s6;
		o1_c    = (48'(cal.p5) <<< 19) + 48'(p6tq_s7 >>> 2) + 48'(p7tsq_s7 >>> 4)
			+ 48'(p8tcu_s7 >>> 11);
		sens_c  = (40'(cal.p1m) <<< 12) + 40'(p2tq_s7 >>> 9) + 40'(p3tsq_s7 >>> 12)
			+ 40'(p4tcu_s7 >>> 17);
		qpp_c   = $signed({1'b0, qp_s7}) * cal.p11;
		o2f     = $signed({1'b0, p_s8}) * sens_s8;
		o3_c    = 48'(o3a_s8) + 48'(qpp_s8 >>> 29);
		sum_c   = 50'(o1_s9) + 50'(o2_s9) + 50'(o3_s9);
		prf     = (sum_c + RND_HALF) >>> RS;
		if (prf < 50'sd0)             res_c.pressure_pa = '0;
		else if (prf > 50'sd8388607)  res_c.pressure_pa = 23'h7fffff;
		else                          res_c.pressure_pa = prf[22:0];
		res_c.temperature_c = tc_s9;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d_s1 <= d_c;
			p_s1 <= in_data.raw_pressure;
		end
		if (en[2]) begin
			dt2_s2 <= dt2_c;
			dd_s2  <= dd_c;
			pp_s2  <= pp_c;
			p_s2   <= p_s1;
		end
		if (en[3]) begin
			num_s3 <= num_c;
			q_s3   <= pp_s2[47:20];
			p_s3   <= p_s2;
		end
		if (en[4]) begin
			tq_s4 <= tqf[24:0];
			tc_s4 <= tc_c;
			q_s4  <= q_s3;
			p_s4  <= p_s3;
		end
		if (en[5]) begin
			tq_s5    <= tq_s4;
			tsq_s5   <= tsqf[48:12];
			p6tq_s5  <= p6tq_c;
			p2tq_s5  <= p2tq_c;
			p10tq_s5 <= p10tq_c;
			tc_s5    <= tc_s4;
			q_s5     <= q_s4;
			p_s5     <= p_s4;
		end
		if (en[6]) begin
			tcu_s6   <= tcuf[59:12];
			p7tsq_s6 <= p7tsq_c;
			p3tsq_s6 <= p3tsq_c;
			coef_s6  <= coef_c;
			p6tq_s6  <= p6tq_s5;
			p2tq_s6  <= p2tq_s5;
			tc_s6    <= tc_s5;
			q_s6     <= q_s5;
			p_s6     <= p_s5;
		end
		if (en[7]) begin
			p8tcu_s7 <= p8tcu_c;
			p4tcu_s7 <= p4tcu_c;
			qc_s7    <= qc_c;
			qp_s7    <= qp_c;
			p6tq_s7  <= p6tq_s6;
			p2tq_s7  <= p2tq_s6;
			p7tsq_s7 <= p7tsq_s6;
			p3tsq_s7 <= p3tsq_s6;
			tc_s7    <= tc_s6;
			p_s7     <= p_s6;
		end
		if (en[8]) begin
			o1_s8   <= o1_c;
			sens_s8 <= sens_c;
			o3a_s8  <= 37'(qc_s7 >>> 24);
			qpp_s8  <= qpp_c;
			tc_s8   <= tc_s7;
			p_s8    <= p_s7;
		end
		if (en[9]) begin
			o1_s9 <= o1_s8;
			o2_s9 <= 48'(o2f >>> 16);
			o3_s9 <= o3_c;
			tc_s9 <= tc_s8;
		end
		if (en[NS+1]) begin
			out_data <= res_c;
		end
	end

	`BPC_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, v_q[1], "accepted beat not in stage 1")
	`BPC_ASSERT_NOW(a_empty_out_no_stall, !ov_q, !in_stall, "input stalled with empty output")
	`BPC_ASSERT_NEXT(a_last_stage_holds, v_q[NS] && !en[NS], v_q[NS], "stalled beat dropped")
endmodule

// ===== rtl/baro_pressure_compensation_top.sv =====
// Top level of the barometer pressure and temperature compensation block.

// One raw pressure/temperature pair goes in per beat and one compensated result comes
// out per beat. The datapath is a ten-register pipeline (nine stages plus the output
// register). A new pair can be taken every cycle while in_stall is low; throughput is
// one pair per clock while the output is not stalled. Stages that hold a bubble keep
// advancing while the output is stalled, so the input side only backs up once every
// stage is full. Temperature comes out in 1/256 degC, pressure in 2^-OUT_FRAC_BITS Pa,
// both saturated. Calibration is written through the cfg port (index 0 temp_calib,
// 1..3 pressure words); the user must write it only while the pipeline is empty, which
// the block does not enforce; cfg_ready is always high.
module baro_pressure_compensation_top #(
	parameter int OUT_FRAC_BITS = bpc_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  bpc_pkg::bpc_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output bpc_pkg::bpc_out_t                 out_data
);
	import bpc_pkg::*;

	logic [39:0] temp_calib_q;
	logic [47:0] press_lo_q;
	logic [47:0] press_mid_q;
	logic [31:0] press_hi_q;
	bpc_calib_t  cal;

	assign cfg_ready = 1'b1;

	// calibration registers; upper data bits beyond each width are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_lo_q   <= '0;
			press_mid_q  <= '0;
			press_hi_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEMP_CALIB: temp_calib_q <= cfg_data[39:0];
				REG_PRESS_LO:   press_lo_q   <= cfg_data;
				REG_PRESS_MID:  press_mid_q  <= cfg_data;
				REG_PRESS_HI:   press_hi_q   <= cfg_data[31:0];
				default:        ;
			endcase
		end
	end

	// unpack into sign-correct coefficients for the datapath
	assign cal = decode_calib(temp_calib_q, press_lo_q, press_mid_q, press_hi_q);

	bpc_pipe #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.cal      (cal),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);
endmodule
